[rtl/fipp_pkg.sv]
// fipp_pkg: shared types, constants and arithmetic helpers for the framed integer pair parser
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package fipp_pkg;

    // body length limit and derived counter width
    localparam int MAX_BODY_CHARS = 255;
    localparam int LEN_W          = $clog2(MAX_BODY_CHARS + 1);

    // payload widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 2;
    localparam int RESULT_BITS = 2 * VALUE_W + COUNT_W + 1;
    localparam int RESULT_W = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = RESULT_W - RESULT_BITS;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E;

    // magnitude cap, one past the largest positive value
    localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

    // field counts
    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

    // parser phases
    typedef enum logic [9:0] {
        PH_HUNT  = 10'b00_0000_0001,
        PH_XWS   = 10'b00_0000_0010,
        PH_XSGN  = 10'b00_0000_0100,
        PH_XDIG  = 10'b00_0000_1000,
        PH_YWS   = 10'b00_0001_0000,
        PH_YSGN  = 10'b00_0010_0000,
        PH_YDIG  = 10'b00_0100_0000,
        PH_DONE0 = 10'b00_1000_0000,
        PH_DONE1 = 10'b01_0000_0000,
        PH_DONE2 = 10'b10_0000_0000
    } phase_t;

    // one parsed frame
    typedef struct packed {
        logic                  frame_too_long;
        logic [COUNT_W-1:0]    fields_parsed;
        logic signed [VALUE_W-1:0] y_value;
        logic signed [VALUE_W-1:0] x_value;
    } result_t;

    // handshake between pipeline stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // mag * 10 + digit, saturated at the magnitude cap
    function automatic logic [VALUE_W-1:0] accumulate(input logic [VALUE_W-1:0] mag,
                                                      input logic [3:0] digit);
        logic [VALUE_W+3:0] prod;
        prod = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {{VALUE_W{1'b0}}, digit};
        if (prod > {4'd0, MAG_CAP})
            accumulate = MAG_CAP;
        else
            accumulate = prod[VALUE_W-1:0];
    endfunction

    // magnitude and sign to two's complement, saturated
    function automatic logic [VALUE_W-1:0] finish(input logic [VALUE_W-1:0] mag,
                                                  input logic neg);
        if (neg)
            finish = {VALUE_W{1'b0}} - mag;
        else if (mag >= MAG_CAP)
            finish = POS_MAX;
        else
            finish = mag;
    endfunction

endpackage

[rtl/fipp_in_reg.sv]
// fipp_in_reg: input register stage holding one received byte
// depends on fipp_pkg
`timescale 1ns / 1ps

module fipp_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fipp_pkg::BYTE_W-1:0] s_byte,
    input  logic                        advance,
    output logic                        byte_valid,
    output logic [fipp_pkg::BYTE_W-1:0] byte_data
);

    logic                        valid_reg;
    logic [fipp_pkg::BYTE_W-1:0] byte_reg;

    // take a new byte when empty or when the held one moves on
    assign s_ready = !valid_reg || advance;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

[rtl/fipp_core.sv]
// fipp_core: frame hunting, scanf style two-integer parse, length check
// depends on fipp_pkg
`timescale 1ns / 1ps

module fipp_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fipp_pkg::stage_ctl_t        ctl,
    input  logic [fipp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_load,
    output fipp_pkg::result_t           res
);

    fipp_pkg::phase_t             phase_reg, phase_next;
    logic [fipp_pkg::VALUE_W-1:0] first_reg, first_next;
    logic [fipp_pkg::VALUE_W-1:0] second_reg, second_next;
    logic                         neg_reg, neg_next;
    logic [fipp_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                         ovl_reg, ovl_next;

    logic                         fire;
    fipp_pkg::phase_t             term_phase;
    logic [fipp_pkg::VALUE_W-1:0] term_x;
    logic [fipp_pkg::VALUE_W-1:0] term_y;
    logic [fipp_pkg::VALUE_W-1:0] acc_in;
    logic [fipp_pkg::VALUE_W-1:0] acc_out;
    logic [fipp_pkg::COUNT_W-1:0] count;
    logic                         c_space;
    logic                         c_digit;
    logic                         c_sign;

    assign fire    = ctl.valid && ctl.advance;
    assign c_space = fipp_pkg::is_space(rx_byte);
    assign c_digit = fipp_pkg::is_digit(rx_byte);
    assign c_sign  = (rx_byte == fipp_pkg::CH_PLUS) || (rx_byte == fipp_pkg::CH_MINUS);

    // end of text: close the number in progress and settle the count
    always_comb
    begin
        term_x = first_reg;
        term_y = second_reg;
        case (phase_reg)
            fipp_pkg::PH_XDIG:
            begin
                term_x     = fipp_pkg::finish(first_reg, neg_reg);
                term_phase = fipp_pkg::PH_DONE1;
            end
            fipp_pkg::PH_YWS,
            fipp_pkg::PH_YSGN:  term_phase = fipp_pkg::PH_DONE1;
            fipp_pkg::PH_YDIG:
            begin
                term_y     = fipp_pkg::finish(second_reg, neg_reg);
                term_phase = fipp_pkg::PH_DONE2;
            end
            fipp_pkg::PH_DONE1: term_phase = fipp_pkg::PH_DONE1;
            fipp_pkg::PH_DONE2: term_phase = fipp_pkg::PH_DONE2;
            default:            term_phase = fipp_pkg::PH_DONE0;
        endcase
    end

    // shared multiply-by-ten accumulator
    always_comb
    begin
        case (phase_reg)
            fipp_pkg::PH_XDIG: acc_in = first_reg;
            fipp_pkg::PH_YDIG: acc_in = second_reg;
            default:           acc_in = '0;
        endcase
        acc_out = fipp_pkg::accumulate(acc_in, rx_byte[3:0]);
    end

    // result fields for a closing marker
    always_comb
    begin
        case (term_phase)
            fipp_pkg::PH_DONE2: count = fipp_pkg::CNT_TWO;
            fipp_pkg::PH_DONE1: count = fipp_pkg::CNT_ONE;
            default:            count = fipp_pkg::CNT_NONE;
        endcase
        res.x_value        = (count != fipp_pkg::CNT_NONE) ? term_x : '0;
        res.y_value        = (count == fipp_pkg::CNT_TWO) ? term_y : '0;
        res.fields_parsed  = count;
        res.frame_too_long = ovl_reg;
    end

    // next state for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        neg_next    = neg_reg;
        len_next    = len_reg;
        ovl_next    = ovl_reg;
        res_load    = 1'b0;
        if (fire)
        begin
            if (phase_reg == fipp_pkg::PH_HUNT)
            begin
                if (rx_byte == fipp_pkg::CH_OPEN)
                begin
                    phase_next = fipp_pkg::PH_XWS;
                    neg_next   = 1'b0;
                    len_next   = '0;
                    ovl_next   = 1'b0;
                end
            end
            else if (rx_byte == fipp_pkg::CH_CLOSE)
            begin
                res_load   = 1'b1;
                phase_next = fipp_pkg::PH_HUNT;
                neg_next   = 1'b0;
                len_next   = '0;
                ovl_next   = 1'b0;
            end
            else if (len_reg >= fipp_pkg::LEN_W'(fipp_pkg::MAX_BODY_CHARS))
            begin
                ovl_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
                if (rx_byte == fipp_pkg::CH_NUL)
                begin
                    phase_next  = term_phase;
                    first_next  = term_x;
                    second_next = term_y;
                end
                else
                begin
                    case (phase_reg)
                        fipp_pkg::PH_XWS,
                        fipp_pkg::PH_YWS:
                        begin
                            if (c_sign)
                            begin
                                neg_next   = (rx_byte == fipp_pkg::CH_MINUS);
                                phase_next = (phase_reg == fipp_pkg::PH_YWS) ?
                                             fipp_pkg::PH_YSGN : fipp_pkg::PH_XSGN;
                            end
                            else if (c_digit)
                            begin
                                if (phase_reg == fipp_pkg::PH_YWS)
                                begin
                                    second_next = acc_out;
                                    phase_next  = fipp_pkg::PH_YDIG;
                                end
                                else
                                begin
                                    first_next = acc_out;
                                    phase_next = fipp_pkg::PH_XDIG;
                                end
                            end
                            else if (!c_space)
                            begin
                                phase_next = (phase_reg == fipp_pkg::PH_YWS) ?
                                             fipp_pkg::PH_DONE1 : fipp_pkg::PH_DONE0;
                            end
                        end
                        fipp_pkg::PH_XSGN:
                        begin
                            if (c_digit)
                            begin
                                first_next = acc_out;
                                phase_next = fipp_pkg::PH_XDIG;
                            end
                            else
                            begin
                                phase_next = fipp_pkg::PH_DONE0;
                            end
                        end
                        fipp_pkg::PH_YSGN:
                        begin
                            if (c_digit)
                            begin
                                second_next = acc_out;
                                phase_next  = fipp_pkg::PH_YDIG;
                            end
                            else
                            begin
                                phase_next = fipp_pkg::PH_DONE1;
                            end
                        end
                        fipp_pkg::PH_XDIG:
                        begin
                            if (c_digit)
                            begin
                                first_next = acc_out;
                            end
                            else if (rx_byte == fipp_pkg::CH_COMMA)
                            begin
                                first_next = term_x;
                                neg_next   = 1'b0;
                                phase_next = fipp_pkg::PH_YWS;
                            end
                            else
                            begin
                                phase_next = term_phase;
                                first_next = term_x;
                            end
                        end
                        fipp_pkg::PH_YDIG:
                        begin
                            if (c_digit)
                            begin
                                second_next = acc_out;
                            end
                            else
                            begin
                                phase_next  = term_phase;
                                second_next = term_y;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fipp_pkg::PH_HUNT;
            neg_reg   <= 1'b0;
            len_reg   <= '0;
            ovl_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            len_reg   <= len_next;
            ovl_reg   <= ovl_next;
        end
    end

    // accumulators, written before they are read in every frame
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= fipp_pkg::LEN_W'(fipp_pkg::MAX_BODY_CHARS))
        else $error("body length counter past limit");

    a_ovl_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovl_reg |-> (len_reg == fipp_pkg::LEN_W'(fipp_pkg::MAX_BODY_CHARS)))
        else $error("overlength flag without full body");

    a_close_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (phase_reg == fipp_pkg::PH_HUNT) && !ovl_reg && (len_reg == '0))
        else $error("frame state not cleared after close");

    a_res_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (res.fields_parsed == fipp_pkg::CNT_TWO) ||
                     ((res.y_value == '0) &&
                      ((res.fields_parsed == fipp_pkg::CNT_ONE) || (res.x_value == '0))))
        else $error("unparsed field not zero");
`endif

endmodule

[rtl/fipp_out_reg.sv]
// fipp_out_reg: result register holding one parsed frame until taken
// depends on fipp_pkg
`timescale 1ns / 1ps

module fipp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fipp_pkg::result_t res_in,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output fipp_pkg::result_t m_res
);

    logic              valid_reg;
    fipp_pkg::result_t res_reg;

    // stage before may move when the register is empty or being emptied
    assign advance = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

[rtl/framed_integer_pair_parser.sv]
// framed_integer_pair_parser: top level, input register, parser core, result register
// depends on fipp_pkg, fipp_in_reg, fipp_core, fipp_out_reg
`timescale 1ns / 1ps

// A closing '>' is held in the input register, and its result is loaded into the result
// register that drives m_axis; a stall on m_axis_tready can hold the '>' in the input register.
// Throughput: one byte per cycle; the parse step sits between the input and result registers.
// s_axis_tready drops only while a finished result waits on m_axis_tready and a byte is held.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to hunting
// for '<'; no clearing pass is needed.

module framed_integer_pair_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fipp_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] x_value, [63:32] y_value, [65:64] fields_parsed, [66] frame_too_long, rest zero
    output logic [fipp_pkg::RESULT_W-1:0] m_axis_tdata
);

    fipp_pkg::stage_ctl_t        ctl;
    logic                        byte_valid;
    logic [fipp_pkg::BYTE_W-1:0] byte_data;
    logic                        advance;
    logic                        res_load;
    fipp_pkg::result_t           res;
    fipp_pkg::result_t           m_res;

    // input register
    fipp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_axis_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    assign ctl.valid   = byte_valid;
    assign ctl.advance = advance;

    // parser
    fipp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rx_byte  (byte_data),
        .res_load (res_load),
        .res      (res)
    );

    // result register
    fipp_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_load),
        .res_in  (res),
        .advance (advance),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    // pack result transaction
    assign m_axis_tdata = {{fipp_pkg::PAD_W{1'b0}}, m_res};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[65:64] != 2'd3))
        else $error("fields_parsed out of range");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && byte_valid) |-> !s_axis_tready)
        else $error("input taken while both stages are blocked");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a waiting transaction");
`endif

endmodule
